/* sv/spiral_magnetic_field_eval_core_macros.svh */
// Assertion macros shared by the spiral field evaluator RTL.
// Included by the modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef SPIRAL_MAGNETIC_FIELD_EVAL_CORE_MACROS_SVH
`define SPIRAL_MAGNETIC_FIELD_EVAL_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// check sampled on clk, off while reset is asserted
`define SMF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check sampled on clk, also live during reset
`define SMF_ASSERT_NORST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SMF_ASSERT(lbl, prop, msg)
`define SMF_ASSERT_NORST(lbl, prop, msg)
`endif
`endif

/* sv/smf_pkg.sv */
// Package for the spiral field evaluator: word widths, register codes and stage types.
// No dependencies; imported by smf_sqrt, smf_div and the top level.
`timescale 1ns / 1ps
package smf_pkg;

    localparam int WORD_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int W           = WORD_WIDTH;
    localparam int MW2         = 2 * W;
    localparam int MW3         = 3 * W;
    localparam int MW4         = 4 * W;
    localparam int LANES       = 3;

    localparam int SUM_W       = 2 * W;
    localparam int SQR_W       = W + 4;
    localparam int SQRT_STAGES = SUM_W / 2;
    localparam int TT_W        = 3 * W;
    localparam int COEF_W      = 3 * W;
    localparam int DEN_W       = 4 * W + FRAC_BITS;
    localparam int D2_W        = DEN_W + 1;
    localparam int REM_W       = D2_W + 1;
    localparam int NUM_W       = 6 * W;
    localparam int DIV_STAGES  = W;

    localparam int CFG_IDX_W   = 2;
    localparam logic [CFG_IDX_W-1:0] REG_REF_RADIUS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIND_SPEED    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_SCALE   = 2'd3;

    localparam logic [W-1:0] ONE_FX = {{(W-1){1'b0}}, 1'b1} << FRAC_BITS;

    typedef struct packed {
        logic adv;
        logic vld;
    } pipe_ctl_t;

    typedef struct packed {
        logic [W-1:0] xm;
        logic [W-1:0] ym;
        logic [W-1:0] zm;
        logic         xn;
        logic         yn;
        logic         zn;
        logic         origin;
    } pos_side_t;

    typedef struct packed {
        pos_side_t        side;
        logic [SUM_W-1:0] rad;
        logic [SQR_W-1:0] rem;
        logic [W-1:0]     root;
    } sq_stage_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [W-1:0]     low;
        logic [D2_W-1:0]  d2;
        logic [W-1:0]     q;
        logic             neg;
        logic             ovf;
    } div_lane_t;

    typedef struct packed {
        logic                        origin;
        div_lane_t [LANES-1:0]       lane;
    } div_stage_t;

endpackage

/* sv/smf_sqrt.sv */
// Pipelined integer square root, two radicand bits per stage, with sideband data.
// Depends on smf_pkg.
`timescale 1ns / 1ps
module smf_sqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  smf_pkg::pipe_ctl_t ctl,
    input  smf_pkg::sq_stage_t sq_in,
    output logic               vld_out,
    output smf_pkg::sq_stage_t sq_out
);
    import smf_pkg::*;

    localparam int N = SQRT_STAGES;

    sq_stage_t      cur     [1:N];
    sq_stage_t      st_next [1:N];
    sq_stage_t      st_reg  [1:N];
    logic [N:1]     vld_reg;

    for (genvar i = 1; i <= N; i++) begin : g_stage
        if (i == 1) begin : g_first
            assign cur[i] = sq_in;
        end
        else begin : g_rest
            assign cur[i] = st_reg[i-1];
        end

        always_comb
        begin
            logic [SQR_W-1:0] rem_sh;
            logic [SQR_W-1:0] trial;
            rem_sh = {cur[i].rem[SQR_W-3:0], cur[i].rad[SUM_W-1:SUM_W-2]};
            trial  = SQR_W'({cur[i].root, 2'b01});
            st_next[i]      = cur[i];
            st_next[i].rad  = {cur[i].rad[SUM_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                st_next[i].rem  = rem_sh - trial;
                st_next[i].root = {cur[i].root[W-2:0], 1'b1};
            end
            else
            begin
                st_next[i].rem  = rem_sh;
                st_next[i].root = {cur[i].root[W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.adv)
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ctl.adv)
        begin
            vld_reg <= {vld_reg[N-1:1], ctl.vld};
        end
    end

    assign vld_out = vld_reg[N];
    assign sq_out  = st_reg[N];

endmodule

/* sv/smf_div.sv */
// Pipelined restoring divider, one quotient bit per stage, three lanes side by side.
// Depends on smf_pkg.
`timescale 1ns / 1ps
module smf_div (
    input  logic                clk,
    input  logic                rst_n,
    input  smf_pkg::pipe_ctl_t  ctl,
    input  smf_pkg::div_stage_t dv_in,
    output logic                vld_out,
    output smf_pkg::div_stage_t dv_out
);
    import smf_pkg::*;

    localparam int N = DIV_STAGES;

    div_stage_t     cur     [1:N];
    div_stage_t     st_next [1:N];
    div_stage_t     st_reg  [1:N];
    logic [N:1]     vld_reg;

    for (genvar i = 1; i <= N; i++) begin : g_stage
        if (i == 1) begin : g_first
            assign cur[i] = dv_in;
        end
        else begin : g_rest
            assign cur[i] = st_reg[i-1];
        end

        always_comb
        begin
            logic [REM_W-1:0] rsh;
            logic [REM_W-1:0] dext;
            logic             ge;
            st_next[i] = cur[i];
            for (int k = 0; k < LANES; k++)
            begin
                rsh  = {cur[i].lane[k].rem[REM_W-2:0], cur[i].lane[k].low[W-1]};
                dext = REM_W'(cur[i].lane[k].d2);
                ge   = (rsh >= dext);
                st_next[i].lane[k].rem = ge ? (rsh - dext) : rsh;
                st_next[i].lane[k].low = {cur[i].lane[k].low[W-2:0], 1'b0};
                st_next[i].lane[k].q   = {cur[i].lane[k].q[W-2:0], ge};
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.adv)
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ctl.adv)
        begin
            vld_reg <= {vld_reg[N-1:1], ctl.vld};
        end
    end

    assign vld_out = vld_reg[N];
    assign dv_out  = st_reg[N];

endmodule

/* sv/spiral_magnetic_field_eval_core.sv */
// Spiral magnetic field evaluator, top level: config registers, multiply stages, output register.
// Depends on smf_pkg, smf_sqrt, smf_div and spiral_magnetic_field_eval_core_macros.svh.
//
// Usage:
//  - Input channel: pos_x/pos_y/pos_z (signed Q16.16) move as one item when in_valid is high
//    and in_stall is low. Output channel: field_x/y/z, origin_flag and saturated move when
//    out_valid is high and out_stall is low.
//  - Throughput: one item per cycle, sustained, as long as the receiver does not stall.
//  - Latency: 83 register stages from accept to out_valid: 3 front stages (magnitudes,
//    squares, sum), 32 square-root stages (two radicand bits each), 13 multiply stages
//    (at most one 32x32 partial product per quantity per stage, accumulated), one rounding
//    stage, one divider setup stage, 32 divider stages (one quotient bit each, all three
//    components in parallel) and the output register.
//  - The whole pipeline moves together: while a result sits in the output register and
//    out_stall is high, every stage holds and in_stall is raised; nothing is lost or repeated.
//  - Reset clears all valid bits and loads R0 = 1.0, Omega = 0, v = 1.0, B0 = 1.0.
//  - Write config (cfg_we, cfg_index, cfg_data) only while the pipeline is empty; stages read
//    the registers directly; R0^2*B0 passes r02_reg, cf_*_reg and coef_reg well before use.
`timescale 1ns / 1ps
`include "spiral_magnetic_field_eval_core_macros.svh"
module spiral_magnetic_field_eval_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [smf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [smf_pkg::W-1:0]               cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [smf_pkg::W-1:0]        pos_x,
    input  logic signed [smf_pkg::W-1:0]        pos_y,
    input  logic signed [smf_pkg::W-1:0]        pos_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [smf_pkg::W-1:0]        field_x,
    output logic signed [smf_pkg::W-1:0]        field_y,
    output logic signed [smf_pkg::W-1:0]        field_z,
    output logic                                origin_flag,
    output logic                                saturated
);
    import smf_pkg::*;

    localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};

    localparam int MUL_STAGES = 13;
    localparam int PP_FIRST   = 5;
    localparam int DIGITS     = 3;
    localparam int M_VLD_W    = MUL_STAGES + 2;

    // multiply stage payload; fields fill in as the item moves down
    typedef struct packed {
        logic                        origin;
        logic                        xn, yn, zn, on, bn;
        logic [W-1:0]                xm, ym, rr;
        logic [MW2-1:0]              rr2, orr, xv, yv, zv;
        logic [MW3-1:0]              rr3, xorr, yorr;
        logic [MW4-1:0]              rv;
        logic [LANES-1:0][TT_W-1:0]  tt;
        logic [LANES-1:0]            tn;
        logic [LANES-1:0][NUM_W-1:0] p;
    } mul_t;

    typedef struct packed {
        logic                        origin;
        logic [LANES-1:0][NUM_W-1:0] n2;
        logic [D2_W-1:0]             d2;
        logic [LANES-1:0]            neg;
    } rnd_t;

    typedef struct packed {
        pos_side_t      side;
        logic [MW2-1:0] xx;
        logic [MW2-1:0] yy;
        logic [MW2-1:0] zz;
    } s2_t;

    function automatic logic [W:0] split_sign(input logic [W-1:0] v);
        logic [W-1:0] m;
        m = v[W-1] ? W'(~v + W'(1)) : v;
        return {v[W-1], m};
    endfunction

    // sign/magnitude sum; on a tie of magnitudes the first operand's sign wins
    function automatic logic [TT_W:0] sm_add(input logic [TT_W-1:0] a, input logic an,
                                             input logic [TT_W-1:0] b, input logic bn);
        logic [TT_W:0] r;
        if (an == bn)
            r = {an, a + b};
        else if (a >= b)
            r = {an, a - b};
        else
            r = {bn, b - a};
        return r;
    endfunction

    // configuration registers
    logic [W-1:0] ref_radius_reg;
    logic [W-1:0] rotation_rate_reg;
    logic [W-1:0] wind_speed_reg;
    logic [W-1:0] field_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_radius_reg    <= ONE_FX;
            rotation_rate_reg <= '0;
            wind_speed_reg    <= ONE_FX;
            field_scale_reg   <= ONE_FX;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_REF_RADIUS:    ref_radius_reg    <= cfg_data;
                REG_ROTATION_RATE: rotation_rate_reg <= cfg_data;
                REG_WIND_SPEED:    wind_speed_reg    <= cfg_data;
                REG_FIELD_SCALE:   field_scale_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // derived config terms; a zero wind speed counts as one LSB
    logic [W-1:0] v_eff;
    logic [W:0]   om_split;
    logic [W:0]   bm_split;

    assign v_eff    = (wind_speed_reg == '0) ? W'(1) : wind_speed_reg;
    assign om_split = split_sign(rotation_rate_reg);
    assign bm_split = split_sign(field_scale_reg);

    // R0^2 * |B0|, built from registered 32x32 products
    logic [MW2-1:0]    r02_reg;
    logic [MW2-1:0]    cf_lo_reg;
    logic [MW2-1:0]    cf_hi_reg;
    logic [COEF_W-1:0] coef_reg;

    always_ff @(posedge clk)
    begin
        r02_reg   <= MW2'(ref_radius_reg) * MW2'(ref_radius_reg);
        cf_lo_reg <= MW2'(r02_reg[W-1:0]) * MW2'(bm_split[W-1:0]);
        cf_hi_reg <= MW2'(r02_reg[MW2-1:W]) * MW2'(bm_split[W-1:0]);
        coef_reg  <= COEF_W'(cf_lo_reg) + (COEF_W'(cf_hi_reg) << W);
    end

    // global advance: the whole pipe moves unless a result is blocked at the output
    logic adv;
    logic out_valid_reg;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // front: magnitudes, squares, sum of squares
    pos_side_t s1_reg, s1_next;
    s2_t       s2_reg, s2_next;
    sq_stage_t s3_reg, s3_next;
    logic      s1_vld_reg, s2_vld_reg, s3_vld_reg;

    always_comb
    begin
        logic [W:0] sx, sy, sz;
        sx = split_sign(pos_x);
        sy = split_sign(pos_y);
        sz = split_sign(pos_z);
        s1_next.xn     = sx[W];
        s1_next.xm     = sx[W-1:0];
        s1_next.yn     = sy[W];
        s1_next.ym     = sy[W-1:0];
        s1_next.zn     = sz[W];
        s1_next.zm     = sz[W-1:0];
        s1_next.origin = (pos_x == '0) && (pos_y == '0) && (pos_z == '0);
    end

    always_comb
    begin
        s2_next.side = s1_reg;
        s2_next.xx   = MW2'(s1_reg.xm) * MW2'(s1_reg.xm);
        s2_next.yy   = MW2'(s1_reg.ym) * MW2'(s1_reg.ym);
        s2_next.zz   = MW2'(s1_reg.zm) * MW2'(s1_reg.zm);
    end

    always_comb
    begin
        // sum of three squares of 2^(W-1)-bounded values fits SUM_W bits
        s3_next.side = s2_reg.side;
        s3_next.rad  = SUM_W'(s2_reg.xx + s2_reg.yy + s2_reg.zz);
        s3_next.rem  = '0;
        s3_next.root = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

    // square root
    pipe_ctl_t sq_ctl;
    logic      sq_vld;
    sq_stage_t sq_out;

    assign sq_ctl.adv = adv;
    assign sq_ctl.vld = s3_vld_reg;

    smf_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (sq_ctl),
        .sq_in   (s3_reg),
        .vld_out (sq_vld),
        .sq_out  (sq_out)
    );

    // multiply stages
    mul_t               mul_reg  [1:MUL_STAGES];
    mul_t               mul_next [1:MUL_STAGES];
    rnd_t               rnd_reg, rnd_next;
    div_stage_t         dvi_reg, dvi_next;
    logic [M_VLD_W-1:0] m_vld_reg;

    // first stage: r^2, |Omega|*r and the position times v
    always_comb
    begin
        mul_next[1]        = '0;
        mul_next[1].origin = sq_out.side.origin;
        mul_next[1].xn     = sq_out.side.xn;
        mul_next[1].yn     = sq_out.side.yn;
        mul_next[1].zn     = sq_out.side.zn;
        mul_next[1].on     = om_split[W];
        mul_next[1].bn     = bm_split[W] ^ sq_out.side.zn;
        mul_next[1].xm     = sq_out.side.xm;
        mul_next[1].ym     = sq_out.side.ym;
        mul_next[1].rr     = sq_out.root;
        mul_next[1].rr2    = MW2'(sq_out.root) * MW2'(sq_out.root);
        mul_next[1].orr    = MW2'(om_split[W-1:0]) * MW2'(sq_out.root);
        mul_next[1].xv     = MW2'(sq_out.side.xm) * MW2'(v_eff);
        mul_next[1].yv     = MW2'(sq_out.side.ym) * MW2'(v_eff);
        mul_next[1].zv     = MW2'(sq_out.side.zm) * MW2'(v_eff);
    end

    for (genvar i = 2; i <= MUL_STAGES; i++) begin : g_mul
        if (i == 2) begin : g_lo
            // low digit of r^2 times r, low digit of |Omega|*r times |x| and |y|
            always_comb
            begin
                mul_next[i]      = mul_reg[i-1];
                mul_next[i].rr3  = MW3'(MW2'(mul_reg[i-1].rr2[W-1:0]) * MW2'(mul_reg[i-1].rr));
                mul_next[i].xorr = MW3'(MW2'(mul_reg[i-1].orr[W-1:0]) * MW2'(mul_reg[i-1].xm));
                mul_next[i].yorr = MW3'(MW2'(mul_reg[i-1].orr[W-1:0]) * MW2'(mul_reg[i-1].ym));
            end
        end
        else if (i == 3) begin : g_hi
            // add the high digits
            always_comb
            begin
                mul_next[i]      = mul_reg[i-1];
                mul_next[i].rr3  = mul_reg[i-1].rr3
                    + (MW3'(MW2'(mul_reg[i-1].rr2[MW2-1:W]) * MW2'(mul_reg[i-1].rr)) << W);
                mul_next[i].xorr = mul_reg[i-1].xorr
                    + (MW3'(MW2'(mul_reg[i-1].orr[MW2-1:W]) * MW2'(mul_reg[i-1].xm)) << W);
                mul_next[i].yorr = mul_reg[i-1].yorr
                    + (MW3'(MW2'(mul_reg[i-1].orr[MW2-1:W]) * MW2'(mul_reg[i-1].ym)) << W);
            end
        end
        else if (i == 4) begin : g_terms
            // signed terms of the three components
            always_comb
            begin
                logic [TT_W-1:0] xvs, yvs, zvs;
                logic [TT_W:0]   sx, sy;
                // x*v and friends scaled by 2^FRAC_BITS give the position times v in raw units
                xvs = TT_W'({mul_reg[i-1].xv, FRAC_BITS'(0)});
                yvs = TT_W'({mul_reg[i-1].yv, FRAC_BITS'(0)});
                zvs = TT_W'({mul_reg[i-1].zv, FRAC_BITS'(0)});
                sx  = sm_add(xvs, mul_reg[i-1].xn, mul_reg[i-1].yorr,
                             mul_reg[i-1].yn ^ mul_reg[i-1].on);
                sy  = sm_add(yvs, mul_reg[i-1].yn, mul_reg[i-1].xorr,
                             !(mul_reg[i-1].xn ^ mul_reg[i-1].on));
                mul_next[i]       = mul_reg[i-1];
                mul_next[i].tt[0] = sx[TT_W-1:0];
                mul_next[i].tn[0] = sx[TT_W];
                mul_next[i].tt[1] = sy[TT_W-1:0];
                mul_next[i].tn[1] = sy[TT_W];
                mul_next[i].tt[2] = zvs;
                mul_next[i].tn[2] = mul_reg[i-1].zn;
            end
        end
        else begin : g_pp
            // numerator: one coef digit times one term digit per stage;
            // the first stages also build r^3 * v one digit of r^3 at a time
            localparam int  PA    = (i - PP_FIRST) / DIGITS;
            localparam int  PB    = (i - PP_FIRST) % DIGITS;
            localparam bit  RV_ON = (i - PP_FIRST) < DIGITS;
            localparam int  RV_D  = RV_ON ? (i - PP_FIRST) : 0;

            always_comb
            begin
                mul_next[i] = mul_reg[i-1];
                for (int k = 0; k < LANES; k++)
                begin
                    mul_next[i].p[k] = mul_reg[i-1].p[k]
                        + (NUM_W'(MW2'(coef_reg[PA*W +: W])
                                  * MW2'(mul_reg[i-1].tt[k][PB*W +: W])) << ((PA + PB) * W));
                end
                if (RV_ON)
                begin
                    mul_next[i].rv = mul_reg[i-1].rv
                        + (MW4'(MW2'(mul_reg[i-1].rr3[RV_D*W +: W]) * MW2'(v_eff))
                           << (RV_D * W));
                end
            end
        end
    end

    // rounding to nearest: floor((2n + d) / 2d)
    always_comb
    begin
        logic [DEN_W-1:0] den;
        den             = DEN_W'({mul_reg[MUL_STAGES].rv, FRAC_BITS'(0)});
        rnd_next.origin = mul_reg[MUL_STAGES].origin;
        rnd_next.d2     = {den, 1'b0};
        for (int k = 0; k < LANES; k++)
        begin
            rnd_next.n2[k]  = {mul_reg[MUL_STAGES].p[k][NUM_W-2:0], 1'b0} + NUM_W'(den);
            rnd_next.neg[k] = mul_reg[MUL_STAGES].bn ^ mul_reg[MUL_STAGES].tn[k];
        end
    end

    // quotient of 2^W or more saturates; otherwise the divider starts on the high part
    always_comb
    begin
        dvi_next.origin = rnd_reg.origin;
        for (int k = 0; k < LANES; k++)
        begin
            dvi_next.lane[k].ovf = (rnd_reg.n2[k][NUM_W-1:W] >= (NUM_W-W)'(rnd_reg.d2));
            dvi_next.lane[k].rem = rnd_reg.n2[k][REM_W+W-1:W];
            dvi_next.lane[k].low = rnd_reg.n2[k][W-1:0];
            dvi_next.lane[k].d2  = rnd_reg.d2;
            dvi_next.lane[k].q   = '0;
            dvi_next.lane[k].neg = rnd_reg.neg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 1; i <= MUL_STAGES; i++)
            begin
                mul_reg[i] <= mul_next[i];
            end
            rnd_reg <= rnd_next;
            dvi_reg <= dvi_next;
        end
    end

    // divider
    pipe_ctl_t  dv_ctl;
    logic       dv_vld;
    div_stage_t dv_out;

    assign dv_ctl.adv = adv;
    assign dv_ctl.vld = m_vld_reg[M_VLD_W-1];

    smf_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (dv_ctl),
        .dv_in   (dvi_reg),
        .vld_out (dv_vld),
        .dv_out  (dv_out)
    );

    // saturate, apply sign, override at the origin
    logic [LANES-1:0][W-1:0] fld_reg, fld_next;
    logic                    origin_reg, origin_next;
    logic                    sat_reg, sat_next;

    always_comb
    begin
        logic [W-1:0] lim;
        logic [W-1:0] qv;
        logic         clip;
        sat_next    = 1'b0;
        origin_next = dv_out.origin;
        for (int k = 0; k < LANES; k++)
        begin
            lim  = dv_out.lane[k].neg ? LIM_NEG : LIM_POS;
            clip = dv_out.lane[k].ovf || (dv_out.lane[k].q > lim);
            qv   = clip ? lim : dv_out.lane[k].q;
            fld_next[k] = dv_out.lane[k].neg ? W'(~qv + W'(1)) : qv;
            if (clip)
                sat_next = 1'b1;
            if (dv_out.origin)
                fld_next[k] = '0;
        end
        if (dv_out.origin)
            sat_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fld_reg    <= fld_next;
            origin_reg <= origin_next;
            sat_reg    <= sat_next;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            m_vld_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg    <= in_valid;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            m_vld_reg     <= {m_vld_reg[M_VLD_W-2:0], sq_vld};
            out_valid_reg <= dv_vld;
        end
    end

    assign out_valid   = out_valid_reg;
    assign field_x     = fld_reg[0];
    assign field_y     = fld_reg[1];
    assign field_z     = fld_reg[2];
    assign origin_flag = origin_reg;
    assign saturated   = sat_reg;

    // components sitting at either end of the range
    logic [LANES-1:0] at_lim;

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            at_lim[k] = (fld_reg[k] == LIM_POS) || (fld_reg[k] == LIM_NEG);
        end
    end

    `SMF_ASSERT(a_origin_zero, out_valid && origin_flag |-> fld_reg == '0 && !saturated, "origin")
    `SMF_ASSERT(a_sat_extreme, out_valid && saturated |-> |at_lim, "saturated, nothing clipped")
    `SMF_ASSERT(a_hold_pipe, out_valid && out_stall |=> $stable(dv_out) && $stable(sq_out), "hold")
    `SMF_ASSERT_NORST(a_reset_empty, !rst_n |-> !out_valid, "output valid during reset")

endmodule
